/* rtl/pcbw_pkg.sv */
`timescale 1ns / 1ps
// Package for the pin change batch writer.
// Holds sizes, register constants, mode and state codes and the scan result struct.
// No dependencies.
package pcbw_pkg;

	localparam int HISTORY_DEPTH = 16;
	localparam int PIN_TOTAL     = 32;
	localparam int BYTE_PINS     = 8;
	localparam int LIMIT_W       = 5;
	localparam int ADDR_W        = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
	localparam logic [ADDR_W-1:0]  BASE_REG    = 7'h40;

	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_STEP  = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SCAN,
		ST_END
	} state_t;

	typedef struct packed {
		logic                 hit;
		logic                 done;
		logic [ADDR_W-1:0]    addr;
		logic [BYTE_PINS-1:0] data;
	} scan_res_t;

endpackage

/* rtl/pin_change_batch_writer.sv */
`timescale 1ns / 1ps
// Pin change batch writer, top level. Uses pcbw_pkg, pcbw_hist_mem and pcbw_scan.
// Set and non-flushing step items complete while busy stays low, one item per cycle.
// A flush holds busy: read, load, scan per snapshot (at most PIN_TOTAL steps each), then end;
// one pin or one write pair per step; each write pair is strobed once the next one is found.
// The receiver cannot stall; the final pair is strobed with last as busy falls.
// Asynchronous reset gives one all-low snapshot with no marks and a history limit of 16.
module pin_change_batch_writer #(
	parameter int HISTORY_DEPTH = pcbw_pkg::HISTORY_DEPTH,
	parameter int PIN_TOTAL     = pcbw_pkg::PIN_TOTAL
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [4:0]                   pin_index,
	input  logic                         pin_level,
	input  logic                         cfg_we,
	input  logic [pcbw_pkg::LIMIT_W-1:0] cfg_wdata,
	output logic                         strobe,
	output logic [pcbw_pkg::ADDR_W-1:0]  reg_address,
	output logic [7:0]                   data_byte,
	output logic                         last
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int PIN_W = $clog2(PIN_TOTAL);
	localparam int PP_W  = $clog2(PIN_TOTAL + pcbw_pkg::BYTE_PINS);
	localparam int LW    = pcbw_pkg::LIMIT_W;

	pcbw_pkg::state_t state_q, state_d;

	logic [LW-1:0]                  lim_q;
	logic [LW-1:0]                  lim_eff;
	logic [CNT_W-1:0]               cnt_q;
	logic [IDX_W-1:0]               idx_q;
	logic [PP_W-1:0]                pin_q;
	logic [PIN_TOTAL-1:0]           cur_lvl_q, cur_mrk_q;
	logic [PIN_TOTAL-1:0]           wlvl_q, wmrk_q;
	logic [2*PIN_TOTAL-1:0]         mem_rdata;
	logic                           pend_v_q;
	logic [pcbw_pkg::ADDR_W-1:0]    pend_addr_q;
	logic [7:0]                     pend_data_q;
	logic                           strobe_q, last_q;
	logic [pcbw_pkg::ADDR_W-1:0]    addr_q;
	logic [7:0]                     data_q;

	logic                           accept, full, is_cur, pin_ok;
	logic                           set_en, step_push, flush_go, mem_re;
	logic                           in_load, in_scan, in_end;
	logic [PIN_W-1:0]               pin_sel;
	logic [PP_W-1:0]                next_pin;
	pcbw_pkg::scan_res_t            sres;

	assign accept  = start & ~busy;
	assign busy    = (state_q != pcbw_pkg::ST_IDLE);
	assign pin_ok  = {1'b0, pin_index} < 6'(PIN_TOTAL);
	assign pin_sel = pin_index[PIN_W-1:0];
	assign is_cur  = CNT_W'(idx_q) == (cnt_q - CNT_W'(1));
	assign full    = LW'(cnt_q) >= lim_eff;

	always_comb begin
		if (lim_q == '0) begin
			lim_eff = LW'(1);
		end else if (lim_q > LW'(HISTORY_DEPTH)) begin
			lim_eff = LW'(HISTORY_DEPTH);
		end else begin
			lim_eff = lim_q;
		end
	end

	pcbw_hist_mem #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (2 * PIN_TOTAL),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (step_push),
		.waddr (IDX_W'(cnt_q - CNT_W'(1))),
		.wdata ({cur_mrk_q, cur_lvl_q}),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	pcbw_scan #(
		.PIN_TOTAL (PIN_TOTAL),
		.PIN_W     (PIN_W),
		.PP_W      (PP_W)
	) u_scan (
		.levels   (wlvl_q),
		.marks    (wmrk_q),
		.pin      (pin_q),
		.next_pin (next_pin),
		.res      (sres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcbw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		set_en    = 1'b0;
		step_push = 1'b0;
		flush_go  = 1'b0;
		mem_re    = 1'b0;
		in_load   = 1'b0;
		in_scan   = 1'b0;
		in_end    = 1'b0;
		case (state_q)
			pcbw_pkg::ST_IDLE: begin
				if (accept) begin
					case (pcbw_pkg::mode_t'(mode))
						pcbw_pkg::MODE_SET: begin
							set_en = 1'b1;
						end
						pcbw_pkg::MODE_STEP: begin
							if (full) begin
								flush_go = 1'b1;
								state_d  = pcbw_pkg::ST_READ;
							end else begin
								step_push = 1'b1;
							end
						end
						pcbw_pkg::MODE_FLUSH: begin
							flush_go = 1'b1;
							state_d  = pcbw_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			pcbw_pkg::ST_READ: begin
				mem_re  = 1'b1;
				state_d = pcbw_pkg::ST_LOAD;
			end
			pcbw_pkg::ST_LOAD: begin
				in_load = 1'b1;
				state_d = pcbw_pkg::ST_SCAN;
			end
			pcbw_pkg::ST_SCAN: begin
				in_scan = 1'b1;
				if (sres.done) begin
					state_d = is_cur ? pcbw_pkg::ST_END : pcbw_pkg::ST_READ;
				end
			end
			pcbw_pkg::ST_END: begin
				in_end  = 1'b1;
				state_d = pcbw_pkg::ST_IDLE;
			end
			default: begin
				state_d = pcbw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q     <= pcbw_pkg::LIMIT_RESET;
			cnt_q     <= CNT_W'(1);
			idx_q     <= '0;
			pin_q     <= '0;
			cur_lvl_q <= '0;
			cur_mrk_q <= '0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			if (set_en && pin_ok && (cur_lvl_q[pin_sel] != pin_level)) begin
				cur_lvl_q[pin_sel] <= pin_level;
				cur_mrk_q[pin_sel] <= 1'b1;
			end
			if (step_push) begin
				cnt_q     <= cnt_q + CNT_W'(1);
				cur_mrk_q <= '0;
			end
			if (flush_go) begin
				idx_q <= '0;
			end
			if (in_load) begin
				pin_q <= '0;
			end
			if (in_scan) begin
				pin_q <= next_pin;
				if (sres.done && !is_cur) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (sres.hit) begin
					pend_v_q <= 1'b1;
					strobe_q <= pend_v_q;
				end
			end
			if (in_end) begin
				cur_mrk_q <= '0;
				cnt_q     <= CNT_W'(1);
				pend_v_q  <= 1'b0;
				strobe_q  <= pend_v_q;
			end
		end
	end

	// payload: hold the pending pair until the next one is found or the flush ends
	always_ff @(posedge clk) begin
		if (in_load) begin
			if (is_cur) begin
				wlvl_q <= cur_lvl_q;
				wmrk_q <= cur_mrk_q;
			end else begin
				wlvl_q <= mem_rdata[PIN_TOTAL-1:0];
				wmrk_q <= mem_rdata[2*PIN_TOTAL-1:PIN_TOTAL];
			end
		end
		if (in_scan && sres.hit) begin
			pend_addr_q <= sres.addr;
			pend_data_q <= sres.data;
			addr_q      <= pend_addr_q;
			data_q      <= pend_data_q;
			last_q      <= 1'b0;
		end
		if (in_end) begin
			addr_q <= pend_addr_q;
			data_q <= pend_data_q;
			last_q <= 1'b1;
		end
	end

	assign strobe      = strobe_q;
	assign reg_address = addr_q;
	assign data_byte   = data_q;
	assign last        = last_q;

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("transfer follows the final write pair");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final write pair outside a flush");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(HISTORY_DEPTH)))
		else $error("snapshot count out of range");

	a_set_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == pcbw_pkg::MODE_SET) |=> !busy && !strobe)
		else $error("set item started a flush or a transfer");

endmodule

/* rtl/pcbw_hist_mem.sv */
`timescale 1ns / 1ps
// Snapshot history store: one write port, one registered read port.
// Depends on nothing but its parameters.
module pcbw_hist_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/pcbw_scan.sv */
`timescale 1ns / 1ps
// Scan step unit: tests one pin of a snapshot, builds the write pair, advances the pin.
// Depends on pcbw_pkg.
module pcbw_scan #(
	parameter int PIN_TOTAL = pcbw_pkg::PIN_TOTAL,
	parameter int PIN_W     = 5,
	parameter int PP_W      = 6
) (
	input  logic [PIN_TOTAL-1:0] levels,
	input  logic [PIN_TOTAL-1:0] marks,
	input  logic [PP_W-1:0]      pin,
	output logic [PP_W-1:0]      next_pin,
	output pcbw_pkg::scan_res_t  res
);

	logic [PIN_TOTAL+pcbw_pkg::BYTE_PINS-1:0] padded;
	logic [PIN_W-1:0]                         idx;

	always_comb begin
		idx            = pin[PIN_W-1:0];
		padded         = {{pcbw_pkg::BYTE_PINS{1'b0}}, levels};
		res.hit        = marks[idx];
		res.data       = padded[idx +: pcbw_pkg::BYTE_PINS];
		res.addr       = pcbw_pkg::BASE_REG + pcbw_pkg::ADDR_W'(idx);
		next_pin       = res.hit ? pin + PP_W'(pcbw_pkg::BYTE_PINS) : pin + PP_W'(1);
		res.done       = next_pin >= PP_W'(PIN_TOTAL);
	end

endmodule
